// ===== rtl/core/iso8601_duration_parser_defines.svh =====
// Assertion macros for the ISO 8601 duration parser.
// No dependencies; included by the top level of the block.
`ifndef ISO8601_DURATION_PARSER_DEFINES_SVH
`define ISO8601_DURATION_PARSER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define ISO_DUR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iso8601_duration_parser: same-cycle check failed");

// Next-cycle implication, held off during reset
`define ISO_DUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iso8601_duration_parser: next-cycle check failed");

`endif

// ===== rtl/core/iso_dur_pkg.sv =====
// Package for the ISO 8601 duration parser: widths, character codes,
// status codes, component masks and scale factors. No dependencies.
package iso_dur_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int TOTAL_WIDTH      = 49;
    localparam int SCALE_WIDTH      = 17;
    localparam int STATUS_WIDTH     = 2;
    localparam int SEEN_WIDTH       = 4;

    typedef logic [7:0]              char_t;
    typedef logic [STATUS_WIDTH-1:0] status_t;
    typedef logic [SEEN_WIDTH-1:0]   seen_t;
    typedef logic [SCALE_WIDTH-1:0]  scale_t;

    // Character codes
    localparam char_t CHAR_P    = 8'h50;
    localparam char_t CHAR_D    = 8'h44;
    localparam char_t CHAR_T    = 8'h54;
    localparam char_t CHAR_H    = 8'h48;
    localparam char_t CHAR_M    = 8'h4D;
    localparam char_t CHAR_S    = 8'h53;
    localparam char_t CHAR_DOT  = 8'h2E;
    localparam char_t CHAR_ZERO = 8'h30;
    localparam char_t CHAR_NINE = 8'h39;

    // Result status codes
    localparam status_t STATUS_VALID        = 2'd0;
    localparam status_t STATUS_INVALID      = 2'd1;
    localparam status_t STATUS_NOT_DURATION = 2'd2;

    // Component seen bits and the masks that each designator checks
    localparam seen_t SEEN_DAY  = 4'b1000;
    localparam seen_t SEEN_HOUR = 4'b0100;
    localparam seen_t SEEN_MIN  = 4'b0010;
    localparam seen_t SEEN_SEC  = 4'b0001;
    localparam seen_t SEEN_DHMS = 4'b1111;
    localparam seen_t SEEN_HMS  = 4'b0111;
    localparam seen_t SEEN_MS   = 4'b0011;

    // Seconds per unit
    localparam scale_t SCALE_DAY  = 17'd86400;
    localparam scale_t SCALE_HOUR = 17'd3600;
    localparam scale_t SCALE_MIN  = 17'd60;
    localparam scale_t SCALE_SEC  = 17'd1;
    localparam scale_t SCALE_NONE = 17'd0;

endpackage

// ===== rtl/core/iso8601_duration_parser.sv =====
// Top level of the ISO 8601 duration parser: character parse, scaling and
// total accumulation. Depends on iso_dur_pkg and iso8601_duration_parser_defines.svh.
//
//  channel | signals                            | direction | moves
//  --------+------------------------------------+-----------+--------------------------
//  in      | in_valid in_ready character last_char   | sink      | one word per character
//  out     | out_valid out_ready total_seconds status| source    | one word per string
//
// One character is taken per cycle, back to back, unless a waiting result holds the pipe.
// A string's result leaves the output register after its last character passes
// through the input register, the scale register and the output register.
// Only a result waiting at a full output register holds the pipe; characters
// that end no string flow on through bubbles meanwhile.
// Reset (rst_n low, asynchronous) empties all stages and clears parse state.
`include "iso8601_duration_parser_defines.svh"

module iso8601_duration_parser #(
    parameter int NUMBER_WIDTH = iso_dur_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          character,
    input  logic                                last_char,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [iso_dur_pkg::TOTAL_WIDTH-1:0] total_seconds,
    output iso_dur_pkg::status_t                status
);

    localparam int TOTAL_W = iso_dur_pkg::TOTAL_WIDTH;
    localparam int PROD_W  = NUMBER_WIDTH + iso_dur_pkg::SCALE_WIDTH;

    // Input register
    logic                s1_valid_reg;
    iso_dur_pkg::char_t  s1_char_reg;
    logic                s1_last_reg;

    // Parse state
    logic                    at_first_char_reg, at_first_char_next;
    logic                    is_duration_reg, is_duration_next;
    logic                    in_fraction_reg, in_fraction_next;
    logic                    pending_digits_reg, pending_digits_next;
    logic [NUMBER_WIDTH-1:0] number_accum_reg, number_accum_next;
    iso_dur_pkg::seen_t      seen_reg, seen_next;
    logic                    invalid_seen_reg, invalid_seen_next;

    // Scale register
    logic                 s2_valid_reg;
    logic                 s2_final_reg;
    iso_dur_pkg::status_t s2_status_reg;
    logic [TOTAL_W-1:0]   s2_prod_reg;

    // Running total and output register
    logic                 total_acc_reg;
    logic [TOTAL_W-1:0]   total_sum_reg;
    logic                 out_valid_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    iso_dur_pkg::status_t out_status_reg;

    // Combinational parse results
    logic                 is_digit;
    logic                 take_des;
    iso_dur_pkg::scale_t  scale;
    iso_dur_pkg::status_t status_c;
    logic [PROD_W-1:0]    prod_full;
    logic [TOTAL_W-1:0]   sum_c;
    logic                 out_free, s2_move, s1_move;

    // Flow control: only a final word can hold the scale stage
    assign out_free = !out_valid_reg || out_ready;
    assign s2_move  = s2_valid_reg && (!s2_final_reg || out_free);
    assign s1_move  = !s2_valid_reg || s2_move;
    assign in_ready = !s1_valid_reg || s1_move;

    assign is_digit = (s1_char_reg >= iso_dur_pkg::CHAR_ZERO)
                   && (s1_char_reg <= iso_dur_pkg::CHAR_NINE);

    // Parse one character and update state
    always_comb
    begin
        at_first_char_next  = at_first_char_reg;
        is_duration_next    = is_duration_reg;
        in_fraction_next    = in_fraction_reg;
        pending_digits_next = pending_digits_reg;
        number_accum_next   = number_accum_reg;
        seen_next           = seen_reg;
        invalid_seen_next   = invalid_seen_reg;
        take_des            = 1'b0;
        scale               = iso_dur_pkg::SCALE_NONE;
        status_c            = iso_dur_pkg::STATUS_VALID;

        if (s1_valid_reg && s1_move)
        begin
            if (at_first_char_reg)
            begin
                at_first_char_next = 1'b0;
                is_duration_next   = (s1_char_reg == iso_dur_pkg::CHAR_P);
            end
            else if (is_duration_reg)
            begin
                if (in_fraction_reg)
                begin
                    take_des = !is_digit;
                end
                else if (is_digit)
                begin
                    number_accum_next = (number_accum_reg << 3) + (number_accum_reg << 1)
                                      + NUMBER_WIDTH'(s1_char_reg[3:0]);
                    pending_digits_next = 1'b1;
                end
                else if (s1_char_reg == iso_dur_pkg::CHAR_DOT)
                begin
                    in_fraction_next = 1'b1;
                end
                else
                begin
                    take_des = 1'b1;
                end

                // Check designator order and pick the scale for its value
                if (take_des)
                begin
                    unique case (s1_char_reg)
                        iso_dur_pkg::CHAR_D:
                        begin
                            if ((seen_reg & iso_dur_pkg::SEEN_DHMS) != '0)
                                invalid_seen_next = 1'b1;
                            else
                            begin
                                seen_next = seen_reg | iso_dur_pkg::SEEN_DAY;
                                scale     = iso_dur_pkg::SCALE_DAY;
                            end
                        end
                        iso_dur_pkg::CHAR_T:
                        begin
                            if ((seen_reg & iso_dur_pkg::SEEN_HMS) != '0)
                                invalid_seen_next = 1'b1;
                        end
                        iso_dur_pkg::CHAR_H:
                        begin
                            if ((seen_reg & iso_dur_pkg::SEEN_HMS) != '0)
                                invalid_seen_next = 1'b1;
                            else
                            begin
                                seen_next = seen_reg | iso_dur_pkg::SEEN_HOUR;
                                scale     = iso_dur_pkg::SCALE_HOUR;
                            end
                        end
                        iso_dur_pkg::CHAR_M:
                        begin
                            if ((seen_reg & iso_dur_pkg::SEEN_MS) != '0)
                                invalid_seen_next = 1'b1;
                            else
                            begin
                                seen_next = seen_reg | iso_dur_pkg::SEEN_MIN;
                                scale     = iso_dur_pkg::SCALE_MIN;
                            end
                        end
                        iso_dur_pkg::CHAR_S:
                        begin
                            if ((seen_reg & iso_dur_pkg::SEEN_SEC) != '0)
                                invalid_seen_next = 1'b1;
                            else
                            begin
                                seen_next = seen_reg | iso_dur_pkg::SEEN_SEC;
                                scale     = iso_dur_pkg::SCALE_SEC;
                            end
                        end
                        default:
                        begin
                            invalid_seen_next = 1'b1;
                        end
                    endcase
                    number_accum_next   = '0;
                    pending_digits_next = 1'b0;
                    in_fraction_next    = 1'b0;
                end
            end

            // Close the string: grade it, then return to reset state
            if (s1_last_reg)
            begin
                if (!is_duration_next)
                    status_c = iso_dur_pkg::STATUS_NOT_DURATION;
                else if (invalid_seen_next || pending_digits_next || in_fraction_next)
                    status_c = iso_dur_pkg::STATUS_INVALID;
                else
                    status_c = iso_dur_pkg::STATUS_VALID;
                at_first_char_next  = 1'b1;
                is_duration_next    = 1'b0;
                in_fraction_next    = 1'b0;
                pending_digits_next = 1'b0;
                number_accum_next   = '0;
                seen_next           = '0;
                invalid_seen_next   = 1'b0;
            end
        end
    end

    // Scale the stored value to seconds; zero scale gives no contribution
    assign prod_full = PROD_W'(number_accum_reg) * PROD_W'(scale);

    // Add the registered product to the running total
    assign sum_c = (total_acc_reg ? total_sum_reg : '0) + s2_prod_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg <= character;
            s1_last_reg <= last_char;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_first_char_reg  <= 1'b1;
            is_duration_reg    <= 1'b0;
            in_fraction_reg    <= 1'b0;
            pending_digits_reg <= 1'b0;
            number_accum_reg   <= '0;
            seen_reg           <= '0;
            invalid_seen_reg   <= 1'b0;
        end
        else
        begin
            at_first_char_reg  <= at_first_char_next;
            is_duration_reg    <= is_duration_next;
            in_fraction_reg    <= in_fraction_next;
            pending_digits_reg <= pending_digits_next;
            number_accum_reg   <= number_accum_next;
            seen_reg           <= seen_next;
            invalid_seen_reg   <= invalid_seen_next;
        end
    end

    // Scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            s2_final_reg  <= s1_last_reg;
            s2_status_reg <= status_c;
            s2_prod_reg   <= TOTAL_W'(prod_full);
        end
    end

    // Running total: drop it once a string closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_acc_reg <= 1'b0;
        end
        else if (s2_move)
        begin
            total_acc_reg <= !s2_final_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            total_sum_reg <= sum_c;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg && s2_final_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg && s2_final_reg)
        begin
            out_total_reg  <= sum_c;
            out_status_reg <= s2_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign total_seconds = out_total_reg;
    assign status        = out_status_reg;

    // Checks
    `ISO_DUR_ASSERT_NOW(a_not_dur_zero, clk, rst_n,
        out_valid && (status == iso_dur_pkg::STATUS_NOT_DURATION), total_seconds == '0)
    `ISO_DUR_ASSERT_NOW(a_accum_has_digits, clk, rst_n,
        number_accum_reg != '0, pending_digits_reg && is_duration_reg)
    `ISO_DUR_ASSERT_NEXT(a_nonfinal_flows, clk, rst_n,
        s2_valid_reg && !s2_final_reg && !s1_valid_reg, !s2_valid_reg)

endmodule
